// ----- src/frame_position_map_queue_unit_macros.svh -----
// Assertion macros shared by the checker of frame_position_map_queue_unit.
// No dependencies; included by the checker file.
`ifndef FRAME_POSITION_MAP_QUEUE_UNIT_MACROS_SVH
`define FRAME_POSITION_MAP_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define FPMQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpmq assertion failed");

// next-cycle implication
`define FPMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpmq assertion failed");

`endif

// ----- src/fpmq_pkg.sv -----
// Shared types, constants and helpers for the frame position map queue.
// No dependencies; used by fpmq_cell, frame_position_map_queue_unit and fpmq_checker.
package fpmq_pkg;

   localparam int MAX_SEGMENTS = 32;
   localparam int FRAME_BITS   = 48;
   localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
   localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
   localparam int LEN_BITS     = 22;
   localparam int RUN_BITS     = 16;
   localparam int RATIO_BITS   = 24;
   localparam int BACKLOG_BITS = 20;
   localparam int SUM_BITS     = LEN_BITS + 1;
   localparam int PROD_BITS    = SUM_BITS + RATIO_BITS;
   localparam int TOTAL_BITS   = LEN_BITS + CNT_BITS;
   localparam int DIST_BITS    = 31;
   localparam int SCALE_SHIFT  = 16;
   localparam int ROUND_HALF   = 32768;

   localparam logic [BACKLOG_BITS-1:0] BACKLOG_RESET = BACKLOG_BITS'(100000);
   localparam logic [DIST_BITS-1:0]    FAR_LIMIT     = '1;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] CELL_HOLD = 2'd0;
   localparam logic [1:0] CELL_UP   = 2'd1;   // take from lower neighbor
   localparam logic [1:0] CELL_DOWN = 2'd2;   // take from upper neighbor
   localparam logic [1:0] CELL_LEN  = 2'd3;   // rewrite length only

   typedef struct packed {
      logic [FRAME_BITS-1:0] src;
      logic [FRAME_BITS-1:0] dst;
      logic [LEN_BITS-1:0]   len;
      logic [RATIO_BITS-1:0] ratio;
   } seg_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [LEN_BITS-1:0] new_len;
   } cell_ctl_type;

   // round(p / 65536), half up
   function automatic logic [FRAME_BITS-1:0] scale_round(input logic [PROD_BITS-1:0] p);
      logic [PROD_BITS:0] t;
      t = {1'b0, p} + (PROD_BITS + 1)'(ROUND_HALF);
      return FRAME_BITS'(t >> SCALE_SHIFT);
   endfunction

   // shorter way round the frame ring
   function automatic logic [FRAME_BITS-1:0] ring_dist(input logic [FRAME_BITS-1:0] x);
      logic [FRAME_BITS-1:0] n;
      n = -x;
      return (x < n) ? x : n;
   endfunction

endpackage

// ----- src/fpmq_cell.sv -----
// One segment cell of the frame position map ring.
// Depends on fpmq_pkg.
module fpmq_cell import fpmq_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  seg_type      from_lo,
   input  seg_type      from_hi,
   output seg_type      seg
);

   seg_type seg_ff;
   seg_type seg_in;

   always_comb begin
      seg_in = seg_ff;
      case (ctl.mode)
         CELL_HOLD: seg_in = seg_ff;
         CELL_UP:   seg_in = from_lo;
         CELL_DOWN: seg_in = from_hi;
         CELL_LEN:  seg_in.len = ctl.new_len;
         default:   seg_in = seg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign seg = seg_ff;

endmodule

// ----- src/frame_position_map_queue_unit.sv -----
// Frame position map queue. Segments live in a ring of MAX_SEGMENTS cells,
// newest in cell 0. Clear and no-op are handled in the idle state. A search
// rotates the ring once, then drains, scales the hit and sends the result.
// An insert runs its setup states and then one full rotation of the ring
// for backlog cleanup.
// Depends on fpmq_pkg and fpmq_cell.
module frame_position_map_queue_unit import fpmq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // source_frame, run_frames, dest_frame, rate_ratio
   input  logic [1:0]   req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // mapped_frame
   output logic         rsp_tuser,   // approximate
   input  logic         csr_tvalid,
   output logic         csr_tready,
   input  logic [23:0]  csr_tdata    // backlog_frames in [19:0]
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_CHK   = 4'd2;
   localparam logic [3:0] ST_SMUL  = 4'd3;
   localparam logic [3:0] ST_SPUSH = 4'd4;
   localparam logic [3:0] ST_PUSH  = 4'd5;
   localparam logic [3:0] ST_CLEAN = 4'd6;
   localparam logic [3:0] ST_SRCH  = 4'd7;
   localparam logic [3:0] ST_DRAIN = 4'd8;
   localparam logic [3:0] ST_HMUL  = 4'd9;
   localparam logic [3:0] ST_SEND  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0] step_ff, step_in;
   logic [BACKLOG_BITS-1:0] backlog_ff, backlog_in;
   logic [CNT_BITS-1:0] keep_ff, keep_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;

   logic [FRAME_BITS-1:0] in_src_ff, in_dst_ff;
   logic [RUN_BITS-1:0]   in_run_ff;
   logic [RATIO_BITS-1:0] in_ratio_ff;
   logic [SUM_BITS-1:0]   older_ff, older_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;

   // search stage A
   logic                  a_vld_ff, a_vld_in;
   logic [FRAME_BITS-1:0] a_off_ff, a_dst_ff;
   logic [LEN_BITS-1:0]   a_len_ff;
   logic [RATIO_BITS-1:0] a_ratio_ff;
   logic [PROD_BITS-1:0]  a_prod_ff;
   // search stage B results
   logic                  found_ff, found_in;
   logic [LEN_BITS-1:0]   hit_off_ff, hit_off_in;
   logic [FRAME_BITS-1:0] hit_dst_ff, hit_dst_in;
   logic [RATIO_BITS-1:0] hit_ratio_ff, hit_ratio_in;
   logic [DIST_BITS-1:0]  best_dist_ff, best_dist_in;
   logic [FRAME_BITS-1:0] best_pos_ff, best_pos_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FRAME_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   seg_type      cell_seg [MAX_SEGMENTS];
   seg_type      lo0, new_seg;
   cell_ctl_type ctl0, ctl_rest;
   logic         push;

   logic walk_last;
   logic req_acc;
   logic [FRAME_BITS-1:0] end_dst, diff, d1, d2;
   logic [SUM_BITS-1:0] sum_len;
   logic merge;
   logic [DIST_BITS-1:0] b1;
   logic [FRAME_BITS-1:0] p1;

   // ring of cells
   assign lo0 = push ? new_seg : cell_seg[MAX_SEGMENTS-1];

   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      if (k == 0) begin : g_head
         fpmq_cell u_cell (
            .clock   (clock),
            .ctl     (ctl0),
            .from_lo (lo0),
            .from_hi (cell_seg[(k + 1) % MAX_SEGMENTS]),
            .seg     (cell_seg[k])
         );
      end else begin : g_body
         fpmq_cell u_cell (
            .clock   (clock),
            .ctl     (ctl_rest),
            .from_lo (cell_seg[k - 1]),
            .from_hi (cell_seg[(k + 1) % MAX_SEGMENTS]),
            .seg     (cell_seg[k])
         );
      end
   end

   assign walk_last = (step_ff == IDX_BITS'(MAX_SEGMENTS - 1));
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign csr_tready = 1'b1;

   // merge test against the newest segment
   assign end_dst = cell_seg[0].dst + scale_round(prod_ff);
   assign diff    = end_dst - in_dst_ff;
   assign sum_len = SUM_BITS'(cell_seg[0].len) + SUM_BITS'(in_run_ff);
   assign merge   = ((cell_seg[0].src + FRAME_BITS'(cell_seg[0].len)) == in_src_ff)
                    && (cell_seg[0].ratio == in_ratio_ff)
                    && (diff == '0 || diff == FRAME_BITS'(1) || diff == '1);

   // distances to start and end edges of stage A's segment
   assign d1 = ring_dist(a_off_ff);
   assign d2 = ring_dist(FRAME_BITS'(a_len_ff) - a_off_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      backlog_in   = backlog_ff;
      keep_in      = keep_ff;
      total_in     = total_ff;
      older_in     = older_ff;
      prod_in      = prod_ff;
      a_vld_in     = 1'b0;
      found_in     = found_ff;
      hit_off_in   = hit_off_ff;
      hit_dst_in   = hit_dst_ff;
      hit_ratio_in = hit_ratio_ff;
      best_dist_in = best_dist_ff;
      best_pos_in  = best_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      push         = 1'b0;
      new_seg      = '{src: in_src_ff, dst: in_dst_ff,
                       len: LEN_BITS'(in_run_ff), ratio: in_ratio_ff};
      ctl0         = '{mode: CELL_HOLD, new_len: sum_len[LEN_BITS-1:0]};
      ctl_rest     = '{mode: CELL_HOLD, new_len: sum_len[LEN_BITS-1:0]};
      b1           = best_dist_ff;
      p1           = best_pos_ff;

      if (csr_tvalid) begin
         backlog_in = csr_tdata[BACKLOG_BITS-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            step_in  = '0;
            keep_in  = '0;
            total_in = '0;
            if (req_acc) begin
               case (req_tuser)
                  OP_INSERT: state_in = (count_ff == '0) ? ST_PUSH : ST_MUL;
                  OP_SEARCH: begin
                     state_in     = ST_SRCH;
                     found_in     = 1'b0;
                     best_dist_in = FAR_LIMIT;
                     best_pos_in  = '0;
                  end
                  OP_CLEAR:  count_in = '0;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(cell_seg[0].len) * PROD_BITS'(cell_seg[0].ratio);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            older_in = sum_len - SUM_BITS'(backlog_ff);
            if (!merge) begin
               state_in = ST_PUSH;
            end else if (sum_len > SUM_BITS'({backlog_ff, 1'b0})) begin
               state_in = ST_SMUL;
            end else begin
               ctl0.mode = CELL_LEN;
               state_in  = ST_CLEAN;
            end
         end
         ST_SMUL: begin
            // older part stays in the newest cell
            prod_in      = PROD_BITS'(older_ff) * PROD_BITS'(in_ratio_ff);
            ctl0.mode    = CELL_LEN;
            ctl0.new_len = older_ff[LEN_BITS-1:0];
            state_in     = ST_SPUSH;
         end
         ST_SPUSH: begin
            new_seg = '{src: cell_seg[0].src + FRAME_BITS'(older_ff),
                        dst: cell_seg[0].dst + scale_round(prod_ff),
                        len: LEN_BITS'(backlog_ff), ratio: in_ratio_ff};
            push          = 1'b1;
            ctl0.mode     = CELL_UP;
            ctl_rest.mode = CELL_UP;
            count_in      = (count_ff == CNT_BITS'(MAX_SEGMENTS)) ? count_ff : count_ff + 1'b1;
            state_in      = ST_CLEAN;
         end
         ST_PUSH: begin
            push          = 1'b1;
            ctl0.mode     = CELL_UP;
            ctl_rest.mode = CELL_UP;
            count_in      = (count_ff == CNT_BITS'(MAX_SEGMENTS)) ? count_ff : count_ff + 1'b1;
            state_in      = ST_CLEAN;
         end
         ST_CLEAN: begin
            // newest first through cell 0
            ctl0.mode     = CELL_DOWN;
            ctl_rest.mode = CELL_DOWN;
            step_in       = step_ff + 1'b1;
            if (keep_ff < count_ff && total_ff < TOTAL_BITS'(backlog_ff)) begin
               keep_in  = keep_ff + 1'b1;
               total_in = total_ff + TOTAL_BITS'(cell_seg[0].len);
            end
            if (walk_last) begin
               count_in = keep_in;
               state_in = ST_IDLE;
            end
         end
         ST_SRCH, ST_DRAIN: begin
            if (state_ff == ST_SRCH) begin
               // oldest first through the top cell
               ctl0.mode     = CELL_UP;
               ctl_rest.mode = CELL_UP;
               step_in       = step_ff + 1'b1;
               a_vld_in      = (({1'b0, 1'b0, step_ff} + {1'b0, count_ff})
                                >= (CNT_BITS + 1)'(MAX_SEGMENTS));
               state_in      = walk_last ? ST_DRAIN : ST_SRCH;
            end else begin
               state_in = ST_HMUL;
            end
            if (a_vld_ff && !found_ff) begin
               if (a_off_ff < FRAME_BITS'(a_len_ff)) begin
                  found_in     = 1'b1;
                  hit_off_in   = a_off_ff[LEN_BITS-1:0];
                  hit_dst_in   = a_dst_ff;
                  hit_ratio_in = a_ratio_ff;
               end else begin
                  if (d1 < FRAME_BITS'(best_dist_ff)) begin
                     b1 = d1[DIST_BITS-1:0];
                     p1 = a_dst_ff;
                  end
                  best_dist_in = b1;
                  best_pos_in  = p1;
                  if (d2 < FRAME_BITS'(b1)) begin
                     best_dist_in = d2[DIST_BITS-1:0];
                     best_pos_in  = a_dst_ff + scale_round(a_prod_ff);
                  end
               end
            end
         end
         ST_HMUL: begin
            prod_in  = PROD_BITS'(hit_off_ff) * PROD_BITS'(hit_ratio_ff);
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = found_ff ? hit_dst_ff + scale_round(prod_ff) : best_pos_ff;
               rsp_user_in  = !found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         backlog_ff   <= BACKLOG_RESET;
         keep_ff      <= '0;
         total_ff     <= '0;
         a_vld_ff     <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         backlog_ff   <= backlog_in;
         keep_ff      <= keep_in;
         total_ff     <= total_in;
         a_vld_ff     <= a_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_src_ff   <= req_tdata[47:0];
         in_run_ff   <= req_tdata[63:48];
         in_dst_ff   <= req_tdata[111:64];
         in_ratio_ff <= req_tdata[135:112];
      end
      older_ff     <= older_in;
      prod_ff      <= prod_in;
      a_off_ff     <= in_src_ff - cell_seg[MAX_SEGMENTS-1].src;
      a_dst_ff     <= cell_seg[MAX_SEGMENTS-1].dst;
      a_len_ff     <= cell_seg[MAX_SEGMENTS-1].len;
      a_ratio_ff   <= cell_seg[MAX_SEGMENTS-1].ratio;
      a_prod_ff    <= PROD_BITS'(cell_seg[MAX_SEGMENTS-1].len)
                      * PROD_BITS'(cell_seg[MAX_SEGMENTS-1].ratio);
      hit_off_ff   <= hit_off_in;
      hit_dst_ff   <= hit_dst_in;
      hit_ratio_ff <= hit_ratio_in;
      best_dist_ff <= best_dist_in;
      best_pos_ff  <= best_pos_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- src/fpmq_checker.sv -----
// Port-level checker for frame_position_map_queue_unit, with its bind.
// Depends on fpmq_pkg and frame_position_map_queue_unit_macros.svh.
`include "frame_position_map_queue_unit_macros.svh"

module fpmq_checker import fpmq_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [47:0]  rsp_tdata,
   input logic         rsp_tuser
);

   // stalled result beat holds
   `FPMQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a search keeps the input closed while the ring is walked
   `FPMQ_ASSERT_NEXT(a_search_busy, clock, reset, req_tvalid && req_tready && req_tuser == OP_SEARCH, !req_tready)

   // a fresh result comes only out of a walk, never from the idle state
   `FPMQ_ASSERT_NOW(a_rsp_from_walk, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

   // no result straight out of reset
   `FPMQ_ASSERT_NOW(a_rsp_reset, clock, reset, $past(reset), !rsp_tvalid)

endmodule

bind frame_position_map_queue_unit fpmq_checker u_fpmq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
